@@ sv/atcl_pkg.sv @@
// Shared constants, widths and sensor tables for the ADC code to temperature unit.
// No dependencies.
`default_nettype none
package atcl_pkg;
	localparam int TABLE_POINTS = 111;
	localparam int FRAC_BITS    = 8;
	localparam int IDX_W        = $clog2(TABLE_POINTS);
	localparam int PT_W         = 22;   // table point in hundredths of an ohm
	localparam int R_W          = 32;   // resistance, Q24.8 ohms
	localparam int RS_W         = 39;   // resistance times 100
	localparam int PROD_W       = 43;   // divider_ohms * code magnitude
	localparam int DVD_W        = 51;   // dividend of the shared divider
	localparam int DVS_W        = 25;   // divisor of the shared divider
	localparam int DIV_CNT_W    = $clog2(DVD_W);
	localparam int CFG_W        = 25;
	localparam int DIVR_W       = 20;
	localparam int FS_W         = 25;
	localparam int CODE_W       = 24;
	localparam int TEMP_W       = 15;
	localparam int CH_W         = 3;
	localparam int STEP_W       = FRAC_BITS + 1;

	localparam logic [TEMP_W-1:0] TEMP_TOP = TEMP_W'((TABLE_POINTS - 1) << FRAC_BITS);

	localparam logic CFG_DIVIDER   = 1'b0;
	localparam logic CFG_FULLSCALE = 1'b1;

	// NTC table, tenths of an ohm
	localparam logic [PT_W-1:0] NTC_DOHM [TABLE_POINTS] = '{
		294900,281500,268900,256900,245500,234600,224300,214500,205200,196300,
		187900,179800,172200,164900,157900,151300,145000,139000,133300,127900,
		122600,117700,112900,108400,104100,100000,96050,92270,88670,85230,
		81940,78800,75790,72910,70160,67520,65000,62580,60260,58050,
		55920,53890,51930,50060,48270,46550,44890,43310,41790,40330,
		38930,37580,36290,35040,33850,32700,31600,30540,29520,28540,
		27600,26690,25820,24970,24170,23390,22640,21910,21220,20550,
		19900,19280,18680,18100,17540,17000,16480,15980,15490,15030,
		14580,14140,13720,13320,12930,12550,12180,11830,11490,11160,
		10840,10530,10230,9942,9663,9393,9132,8879,8634,8397,
		8168,7946,7731,7523,7321,7126,6936,6753,6575,6403,
		6235
	};

	// RTD-100 table, hundredths of an ohm
	localparam logic [PT_W-1:0] RTD_COHM [TABLE_POINTS] = '{
		10000,10039,10078,10117,10156,10195,10234,10273,10312,10351,
		10390,10429,10468,10507,10546,10585,10624,10663,10702,10740,
		10779,10818,10857,10896,10935,10973,11012,11051,11090,11128,
		11167,11206,11245,11283,11322,11361,11399,11438,11477,11515,
		11554,11593,11631,11670,11708,11747,11785,11824,11862,11901,
		11940,11978,12016,12055,12093,12132,12170,12209,12247,12286,
		12324,12362,12401,12439,12477,12517,12555,12593,12632,12670,
		12708,12746,12785,12823,12861,12899,12938,12976,13014,13052,
		13090,13128,13167,13205,13243,13281,13319,13357,13395,13433,
		13471,13509,13547,13585,13623,13661,13699,13737,13775,13813,
		13851,13889,13927,13965,14003,14039,14077,14115,14153,14191,
		14229
	};

	// Table point k in hundredths of an ohm
	function automatic logic [PT_W-1:0] tbl_point(input logic rtd, input logic [IDX_W-1:0] k);
		logic [PT_W-1:0] d;
		d = '0;
		if (k < IDX_W'(TABLE_POINTS)) begin
			if (rtd) begin
				d = RTD_COHM[k];
			end else begin
				d = (NTC_DOHM[k] << 3) + (NTC_DOHM[k] << 1);
			end
		end
		return d;
	endfunction

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic done;
	} div_stat_t;
endpackage
`default_nettype wire

@@ sv/atcl_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on atcl_pkg.
`default_nettype none
module atcl_div import atcl_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_ctl_t         ctl,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output div_stat_t             stat,
	output logic      [DVD_W-1:0] quotient
);
	logic [DVS_W-1:0]     rem_q;
	logic [DVD_W-1:0]     quo_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVS_W:0]       trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign stat.done = done_q;
	assign quotient  = quo_q;
endmodule
`default_nettype wire

@@ sv/adc_code_to_temperature_lut_unit.sv @@
// ADC code to temperature: divider resistance, then table search and interpolation.
// The resistance comes from a divider pass, skipped for a non-positive code or one
// at/above full scale; it is scaled and checked against both table ends. A result that
// does not clamp comes from a segment-by-segment scan and, for a non-zero span, a second
// divider pass for the interpolation step. Input stalls until the result register takes
// the beat; the next is accepted in the cycle after that. One beat in flight at a time.
// Reset (arst_n low, async) clears the sequencer and valids and loads
// divider_ohms = 10000 and full_scale_code = 8388608.
// Depends on atcl_pkg and atcl_div.
`default_nettype none
module adc_code_to_temperature_lut_unit import atcl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              mode,
	input  wire logic [CH_W-1:0]   channel,
	input  wire logic [CODE_W-1:0] adc_code,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CH_W-1:0]        channel_out,
	output logic [TEMP_W-1:0]      temperature_q8,
	output logic                   clamped
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DIV_R, ST_SCALE, ST_CHECK, ST_SCAN, ST_DIV_T, ST_DONE
	} state_t;

	state_t              state_q;
	logic [DIVR_W-1:0]   divr_q;
	logic [FS_W-1:0]     fs_q;
	logic                rtd_q;
	logic [CH_W-1:0]     ch_q;
	logic [PROD_W-1:0]   prod_q;
	logic [R_W-1:0]      r_q;
	logic [RS_W-1:0]     rs_q;
	logic [IDX_W-1:0]    idx_q;
	logic [TEMP_W-1:0]   temp_q;
	logic                clamp_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [DVS_W-1:0]    dvs_q;
	logic                start_q;
	logic                out_valid_q;
	logic [CH_W-1:0]     out_ch_q;
	logic [TEMP_W-1:0]   out_temp_q;
	logic                out_clamp_q;

	div_ctl_t            div_ctl;
	div_stat_t           div_stat;
	logic [DVD_W-1:0]    quot;

	// input side
	logic [CODE_W-2:0]   mag;
	logic                code_le0;
	logic                code_sat;
	// search
	logic [IDX_W-1:0]    idx_n;
	logic [PT_W-1:0]     pt_a, pt_b, pt_first, pt_last, pt_lo, pt_hi;
	logic [RS_W-1:0]     sc_lo, sc_hi, sc_b, sc_first, sc_last;
	logic                seg_hit, cold, hot;
	logic [RS_W-1:0]     num;
	logic [PT_W-1:0]     span;
	logic                accept;

	assign mag      = adc_code[CODE_W-2:0];
	assign code_le0 = adc_code[CODE_W-1] || (adc_code == '0);
	assign code_sat = FS_W'(mag) >= fs_q;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// Table access: two points of the current segment plus both end points
	assign idx_n    = idx_q + IDX_W'(1);
	assign pt_a     = tbl_point(rtd_q, idx_q);
	assign pt_b     = tbl_point(rtd_q, idx_n);
	assign pt_first = tbl_point(rtd_q, '0);
	assign pt_last  = tbl_point(rtd_q, IDX_W'(TABLE_POINTS - 1));
	assign pt_lo    = rtd_q ? pt_a : pt_b;
	assign pt_hi    = rtd_q ? pt_b : pt_a;
	assign sc_lo    = RS_W'({pt_lo, {FRAC_BITS{1'b0}}});
	assign sc_hi    = RS_W'({pt_hi, {FRAC_BITS{1'b0}}});
	assign sc_b     = RS_W'({pt_b, {FRAC_BITS{1'b0}}});
	assign sc_first = RS_W'({pt_first, {FRAC_BITS{1'b0}}});
	assign sc_last  = RS_W'({pt_last, {FRAC_BITS{1'b0}}});
	assign seg_hit  = (rs_q >= sc_lo) && (rs_q <= sc_hi);
	// cold end is point 0, hot end the last point; direction follows the table
	assign cold     = rtd_q ? (rs_q < sc_first) : (rs_q > sc_first);
	assign hot      = rtd_q ? (rs_q > sc_last) : (rs_q < sc_last);
	assign num      = rtd_q ? (sc_b - rs_q) : (rs_q - sc_b);
	assign span     = pt_hi - pt_lo;

	assign div_ctl.start = start_q;

	atcl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (dvd_q),
		.divisor  (dvs_q),
		.stat     (div_stat),
		.quotient (quot)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divr_q <= DIVR_W'(10000);
			fs_q   <= FS_W'(8388608);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_DIVIDER:   divr_q <= cfg_data[DIVR_W-1:0];
				CFG_FULLSCALE: fs_q   <= cfg_data[FS_W-1:0];
				default:       ;
			endcase
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rtd_q  <= mode;
						ch_q   <= channel;
						prod_q <= PROD_W'(divr_q) * PROD_W'(mag);
						dvs_q  <= fs_q - FS_W'(mag);
						if (code_le0) begin
							r_q     <= '0;
							state_q <= ST_SCALE;
						end else if (code_sat) begin
							r_q     <= '1;
							state_q <= ST_SCALE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					dvd_q   <= {prod_q, {FRAC_BITS{1'b0}}};
					start_q <= 1'b1;
					state_q <= ST_DIV_R;
				end
				ST_DIV_R: begin
					if (div_stat.done) begin
						// quotient beyond 32 bits saturates
						r_q     <= (|quot[DVD_W-1:R_W]) ? '1 : quot[R_W-1:0];
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					rs_q    <= RS_W'(r_q) * RS_W'(100);
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					idx_q <= '0;
					if (cold) begin
						temp_q  <= '0;
						clamp_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (hot) begin
						temp_q  <= TEMP_TOP;
						clamp_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						clamp_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (seg_hit) begin
						if (span == '0) begin
							temp_q  <= {idx_n, {FRAC_BITS{1'b0}}};
							state_q <= ST_DONE;
						end else begin
							// rounded-up step: (num + span - 1) / span
							dvd_q   <= DVD_W'(num) + DVD_W'(span) - DVD_W'(1);
							dvs_q   <= DVS_W'(span);
							start_q <= 1'b1;
							state_q <= ST_DIV_T;
						end
					end else if (idx_q == IDX_W'(TABLE_POINTS - 2)) begin
						temp_q  <= TEMP_TOP;
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_n;
					end
				end
				ST_DIV_T: begin
					if (div_stat.done) begin
						temp_q  <= {idx_n, {FRAC_BITS{1'b0}}} - TEMP_W'(quot[STEP_W-1:0]);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hand over once the result register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_ch_q    <= ch_q;
						out_temp_q  <= temp_q;
						out_clamp_q <= clamp_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign channel_out    = out_ch_q;
	assign temperature_q8 = out_temp_q;
	assign clamped        = out_clamp_q;
endmodule
`default_nettype wire
